// ----- sv/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and codes of the RPN stack calculator
// Token and status codes, item payloads and the controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int unsigned DataW = 32;

  // token codes
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_MUL    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;
  localparam logic [2:0] OP_FINISH = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] digit;
  } rpn_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [1:0]              status;
  } rpn_out_t;

  // controller -> datapath
  typedef struct packed {
    logic       in_latch;
    logic       rd_en;
    logic       rd_second;
    logic       push;
    logic       wr_res;
    logic       clr;
    logic       cap_right;
    logic       cap_left;
    logic       exec;
    logic       div_start;
    logic       cap_div;
    logic       out_load;
    logic       out_from_mem;
    logic [1:0] out_status;
  } rpn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] op;
    logic       full;
    logic       empty;
    logic       lt2;
    logic       right_zero;
    logic       div_done;
    logic       out_free;
  } rpn_stat_t;

endpackage

`default_nettype wire

// ----- sv/rpn_div.sv -----
// ----------------------------------------------------------------------------
// rpn_div: iterative signed divider
// Restoring division of magnitudes, one quotient bit per cycle, truncating
// toward zero. The most negative value over minus one wraps.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_div
  import rpn_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DataW-1:0] dividend_i,
  input  wire logic [DataW-1:0] divisor_i,
  output logic                  done_o,
  output logic [DataW-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic              busy_q, done_q, neg_q;
  logic [CntW-1:0]   cnt_q;
  logic [DataW-1:0]  rem_q, quo_q, bmag_q;
  logic [DataW:0]    partial, diff;

  assign partial = {rem_q, quo_q[DataW-1]};
  assign diff    = partial - {1'b0, bmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i[DataW-1] ? (~dividend_i + 1'b1) : dividend_i;
      bmag_q <= divisor_i[DataW-1] ? (~divisor_i + 1'b1) : divisor_i;
      neg_q  <= dividend_i[DataW-1] ^ divisor_i[DataW-1];
    end else if (busy_q) begin
      if (!diff[DataW]) begin
        rem_q <= diff[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_q <= partial[DataW-1:0];
        quo_q <= {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

`default_nettype wire

// ----- sv/rpn_dpath.sv -----
// ----------------------------------------------------------------------------
// rpn_dpath: datapath of the RPN stack calculator
// Operand stack memory, depth counter, operand and result registers,
// multiplier, divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_dpath
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rpn_in_t   in_data_i,
  input  wire rpn_cmd_t  cmd_i,
  input  wire logic      out_ready_i,
  output rpn_stat_t      stat_o,
  output logic           out_valid_o,
  output rpn_out_t       out_data_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  logic [DataW-1:0] mem [STACK_DEPTH];
  logic [DataW-1:0] rdata_q;

  logic [DW-1:0]    depth_q, dm1, dm2;
  logic [2:0]       op_q;
  logic [3:0]       digit_q;
  logic [DataW-1:0] left_q, right_q, res_q, alu;
  logic [DataW-1:0] div_quot;
  logic             div_done;
  logic             out_valid_q;
  rpn_out_t         out_q;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [DataW-1:0] wdata;

  assign dm1   = depth_q - DW'(1);
  assign dm2   = depth_q - DW'(2);
  assign raddr = cmd_i.rd_second ? dm2[AW-1:0] : dm1[AW-1:0];
  assign we    = cmd_i.push | cmd_i.wr_res;
  assign waddr = cmd_i.push ? depth_q[AW-1:0] : dm2[AW-1:0];
  assign wdata = cmd_i.push ? {{(DataW-4){1'b0}}, digit_q} : res_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        depth_q <= '0;
      end else if (cmd_i.push) begin
        depth_q <= depth_q + DW'(1);
      end else if (cmd_i.wr_res) begin
        depth_q <= dm1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // add, sub or low word of the product
  always_comb begin
    case (op_q)
      OP_ADD:  alu = left_q + right_q;
      OP_SUB:  alu = left_q - right_q;
      default: alu = left_q * right_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_latch) begin
      op_q    <= in_data_i.operation;
      digit_q <= in_data_i.digit;
    end
    if (cmd_i.cap_right) right_q <= rdata_q;
    if (cmd_i.cap_left)  left_q  <= rdata_q;
    if (cmd_i.exec) begin
      res_q <= alu;
    end else if (cmd_i.cap_div) begin
      res_q <= div_quot;
    end
    if (cmd_i.out_load) begin
      out_q.value  <= cmd_i.out_from_mem ? rdata_q : '0;
      out_q.status <= cmd_i.out_status;
    end
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (left_q),
    .divisor_i  (right_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    stat_o.op         = op_q;
    stat_o.full       = (depth_q == DW'(STACK_DEPTH));
    stat_o.empty      = (depth_q == '0);
    stat_o.lt2        = (depth_q < DW'(2));
    stat_o.right_zero = (right_q == '0);
    stat_o.div_done   = div_done;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/rpn_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpn_ctrl: sequencer of the RPN stack calculator
// Decodes one token and steps the datapath through reads, the operation,
// the write-back and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ctrl
  import rpn_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire rpn_stat_t stat_i,
  output logic           in_ready_o,
  output rpn_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_LEFT,
    S_CAP_LEFT,
    S_EXEC,
    S_DIV_WAIT,
    S_WRITE,
    S_FINISH,
    S_ERROR
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] err_q, err_d;

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    cmd_o       = '0;
    cmd_o.out_status = err_q;
    in_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.in_latch = in_valid_i;
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.op)
          OP_PUSH: begin
            if (stat_i.full) begin
              err_d   = ST_OVERFLOW;
              state_d = S_ERROR;
            end else begin
              cmd_o.push = 1'b1;
              state_d    = S_IDLE;
            end
          end
          OP_FINISH: begin
            if (stat_i.empty) begin
              err_d   = ST_UNDERFLOW;
              state_d = S_ERROR;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_FINISH;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (stat_i.lt2) begin
              err_d   = ST_UNDERFLOW;
              state_d = S_ERROR;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_RD_LEFT;
            end
          end
          default: state_d = S_IDLE;  // unused codes are dropped
        endcase
      end
      S_RD_LEFT: begin
        cmd_o.cap_right = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_second = 1'b1;
        state_d         = S_CAP_LEFT;
      end
      S_CAP_LEFT: begin
        cmd_o.cap_left = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.op == OP_DIV) begin
          if (stat_i.right_zero) begin
            err_d   = ST_DIVZERO;
            state_d = S_ERROR;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV_WAIT;
          end
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = S_WRITE;
        end
      end
      S_DIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.cap_div = 1'b1;
          state_d       = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_res = 1'b1;
        state_d      = S_IDLE;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_from_mem = 1'b1;
          cmd_o.out_status   = ST_OK;
          cmd_o.clr          = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_ERROR: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clr      = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rpn_stack_calculator.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_calculator: Reverse Polish evaluator over a 32-bit operand stack
// Top level: controller, datapath and the interface checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one token
//   per item: push digit, add, subtract, multiply, divide or finish.
//   Output channel (out_valid_o / out_ready_i / out_data_o) carries one
//   result item per finish token or per error; other tokens give none.
//   Errors (overflow, underflow, divide by zero) return value zero with the
//   status code and empty the stack.
// Sequence per token:
//   push decodes and writes; add, subtract, multiply read both operands,
//   compute and write back; divide waits on the one-bit-per-cycle divider
//   (32 steps and a done strobe) before the write-back. Finish, overflow
//   and short-stack errors are found at decode, divide by zero once both
//   operands are read; the next token is taken in the cycle after the result is loaded.
//   Operands come from a single-read-port stack memory, one per cycle.
// Reset clears the depth count and the output valid flag; stack contents
//   are not cleared and need no clearing pass.
// Stall: the result sits in an output register; a token that produces a
//   new result waits until the previous one is taken. Tokens that give no
//   result keep flowing while the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire rpn_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output rpn_out_t     out_data_o
);

  rpn_cmd_t  cmd;
  rpn_stat_t stat;

  // sequencer: one token at a time
  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  // stack memory, arithmetic and result register
  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // an accepted item always takes a decode cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted item");

  // error results carry a zero value
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> (out_data_o.value == '0))
    else $error("error result with nonzero value");

  // a result only appears while a token is being worked on
  a_result_from_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a token in work");

  // push never writes into a full stack
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !stat.full)
    else $error("push into a full stack");

endmodule

`default_nettype wire
